@@ sv/uee_pkg.sv @@
package uee_pkg;

    // control sequence of the edge extractor
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_DEC,
        S_EMIT
    } t_state;

    localparam int OUT_DATA_W = 40;
    localparam int SLOT_OUT_W = 8;
    localparam int VERT_OUT_W = 16;

endpackage

@@ sv/uee_cell.sv @@
module uee_cell #(
    parameter int VERTEX_BITS = 16,
    parameter int CNT_W       = 9,
    parameter int IDX         = 0
) (
    input  logic                   i_clk,
    input  logic                   i_shift,
    input  logic [VERTEX_BITS-1:0] i_prev_a,
    input  logic [VERTEX_BITS-1:0] i_prev_b,
    input  logic [VERTEX_BITS-1:0] i_key_a,
    input  logic [VERTEX_BITS-1:0] i_key_b,
    input  logic [CNT_W-1:0]       i_count,
    output logic [VERTEX_BITS-1:0] o_a,
    output logic [VERTEX_BITS-1:0] o_b,
    output logic                   o_hit
);

    logic [VERTEX_BITS-1:0] r_a;
    logic [VERTEX_BITS-1:0] r_b;
    logic                   r_hit;
    logic                   occupied;
    logic                   n_hit;

    // newest edge sits in cell 0, so the cells below the fill count hold edges
    assign occupied = (CNT_W'(IDX) < i_count);

    assign n_hit = occupied &&
                   (((r_a == i_key_a) && (r_b == i_key_b)) ||
                    ((r_a == i_key_b) && (r_b == i_key_a)));

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_a <= i_prev_a;
            r_b <= i_prev_b;
        end
    end

    // hit is only looked at in the cycle after a compare
    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
    end

    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_hit = r_hit;

endmodule

@@ sv/uee_chain.sv @@
module uee_chain #(
    parameter int EDGE_SLOTS  = 256,
    parameter int VERTEX_BITS = 16,
    parameter int CNT_W       = 9
) (
    input  logic                   i_clk,
    input  logic                   i_shift,
    input  logic [VERTEX_BITS-1:0] i_key_a,
    input  logic [VERTEX_BITS-1:0] i_key_b,
    input  logic [CNT_W-1:0]       i_count,
    output logic                   o_hit_any
);

    logic [VERTEX_BITS-1:0] w_a [EDGE_SLOTS+1];
    logic [VERTEX_BITS-1:0] w_b [EDGE_SLOTS+1];
    logic [EDGE_SLOTS-1:0]  w_hit;

    // an append shifts the key in at the head and every entry moves one cell on
    assign w_a[0] = i_key_a;
    assign w_b[0] = i_key_b;

    // the last cell's outputs are left unread: appends stop once the table is full
    for (genvar g = 0; g < EDGE_SLOTS; g++) begin : g_cell
        uee_cell #(
            .VERTEX_BITS (VERTEX_BITS),
            .CNT_W       (CNT_W),
            .IDX         (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_shift  (i_shift),
            .i_prev_a (w_a[g]),
            .i_prev_b (w_b[g]),
            .i_key_a  (i_key_a),
            .i_key_b  (i_key_b),
            .i_count  (i_count),
            .o_a      (w_a[g+1]),
            .o_b      (w_b[g+1]),
            .o_hit    (w_hit[g])
        );
    end

    assign o_hit_any = |w_hit;

endmodule

@@ sv/unique_edge_extractor.sv @@
// Unique edge extractor: takes polygon face vertex indices one transfer at a time
// (s_axis_tlast marks the last vertex of a face, s_axis_tuser starts a new mesh and
// empties the edge table) and emits every undirected edge the first time it is
// seen, with the table slot where it was stored, or with the dropped flag when
// the table is full. The table is a row of EDGE_SLOTS cells; each compares its
// edge against the broadcast key in parallel and an append shifts the whole row
// by one cell. An item is accepted, then each edge it forms is compared in the cells
// and then decided and appended, and each new edge's result is loaded into the
// output register, which stalls while the output side holds m_axis_tready low.
// Items are handled one at a time; the next item is taken once the current one is
// done, with its last result, if any, sitting in the output register.
module unique_edge_extractor
    import uee_pkg::*;
#(
    parameter int EDGE_SLOTS  = 256,
    parameter int VERTEX_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // vertex_index[15:0]
    input  logic                  s_axis_tlast,   // face_end
    input  logic                  s_axis_tuser,   // new_mesh
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // edge_start[15:0], edge_end[31:16],
                                                  // edge_slot[39:32]
    output logic                  m_axis_tlast,   // final_of_item
    output logic                  m_axis_tuser    // dropped
);

    localparam int CNT_W = $clog2(EDGE_SLOTS + 1);
    localparam int VB    = VERTEX_BITS;

    t_state r_state;
    t_state n_state;

    logic [VB-1:0]    r_first;
    logic [VB-1:0]    r_prev;
    logic             r_inside;
    logic [CNT_W-1:0] r_count;
    logic [VB-1:0]    r_ea0;
    logic [VB-1:0]    r_eb0;
    logic [VB-1:0]    r_ea1;
    logic [VB-1:0]    r_eb1;
    logic             r_pend1;
    logic             r_sel;
    logic [1:0]       r_hold;
    logic [SLOT_OUT_W-1:0] r_hold_slot [2];
    logic [1:0]       r_hold_drop;

    logic                  r_out_valid;
    logic [VERT_OUT_W-1:0] r_out_a;
    logic [VERT_OUT_W-1:0] r_out_b;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic                  r_out_drop;
    logic                  r_out_last;

    logic [VB+15:0]        w_in_ext;
    logic [VB-1:0]         w_v;
    logic                  w_inside_eff;
    logic [VB-1:0]         w_first_eff;
    logic [VB-1:0]         w_cur_a;
    logic [VB-1:0]         w_cur_b;
    logic                  w_hit_any;
    logic                  w_full;
    logic [CNT_W+7:0]      w_cnt_ext;
    logic                  w_accept;
    logic                  w_dec_new;
    logic                  w_append;
    logic                  w_out_free;
    logic                  w_pick;
    logic                  w_pick_last;
    logic [VB-1:0]         w_pick_a;
    logic [VB-1:0]         w_pick_b;
    logic [VB+15:0]        w_pick_a_ext;
    logic [VB+15:0]        w_pick_b_ext;
    logic                  w_load_out;

    assign w_in_ext     = {{VB{1'b0}}, s_axis_tdata};
    assign w_v          = w_in_ext[VB-1:0];
    assign w_inside_eff = r_inside & ~s_axis_tuser;
    assign w_first_eff  = w_inside_eff ? r_first : w_v;

    assign w_cur_a = r_sel ? r_ea1 : r_ea0;
    assign w_cur_b = r_sel ? r_eb1 : r_eb0;

    assign w_full    = (r_count == CNT_W'(EDGE_SLOTS));
    assign w_cnt_ext = {8'd0, r_count};

    assign w_out_free  = ~r_out_valid | m_axis_tready;
    assign w_pick      = ~r_hold[0];
    assign w_pick_last = w_pick | ~r_hold[1];
    assign w_pick_a    = w_pick ? r_ea1 : r_ea0;
    assign w_pick_b    = w_pick ? r_eb1 : r_eb0;
    assign w_pick_a_ext = {16'd0, w_pick_a};
    assign w_pick_b_ext = {16'd0, w_pick_b};

    uee_chain #(
        .EDGE_SLOTS  (EDGE_SLOTS),
        .VERTEX_BITS (VB),
        .CNT_W       (CNT_W)
    ) u_chain (
        .i_clk     (i_clk),
        .i_shift   (w_append),
        .i_key_a   (w_cur_a),
        .i_key_b   (w_cur_b),
        .i_count   (r_count),
        .o_hit_any (w_hit_any)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (w_inside_eff || s_axis_tlast)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                if (!r_sel && r_pend1) begin
                    n_state = S_CMP;
                end else if (w_dec_new || (r_hold != 2'b00)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_out_free && w_pick_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_dec_new     = 1'b0;
        w_append      = 1'b0;
        w_load_out    = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_DEC: begin
                w_dec_new = ~w_hit_any;
                w_append  = ~w_hit_any & ~w_full;
            end
            S_EMIT: begin
                w_load_out = w_out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign w_accept = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= '0;
            r_prev      <= '0;
            r_inside    <= 1'b0;
            r_count     <= '0;
            r_pend1     <= 1'b0;
            r_sel       <= 1'b0;
            r_hold      <= 2'b00;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_accept) begin
                r_first  <= w_first_eff;
                r_prev   <= w_v;
                r_inside <= ~s_axis_tlast;
                r_pend1  <= s_axis_tlast;
                r_sel    <= ~w_inside_eff;
                r_hold   <= 2'b00;
                if (s_axis_tuser) begin
                    r_count <= '0;
                end
            end

            if (w_dec_new) begin
                r_hold[r_sel] <= 1'b1;
            end
            if (w_append) begin
                r_count <= r_count + CNT_W'(1);
            end
            if ((r_state == S_DEC) && !r_sel && r_pend1) begin
                r_sel <= 1'b1;
            end

            if (w_load_out) begin
                r_hold[w_pick] <= 1'b0;
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ea0 <= r_prev;
            r_eb0 <= w_v;
            r_ea1 <= w_v;
            r_eb1 <= w_first_eff;
        end
        if (w_dec_new) begin
            r_hold_slot[r_sel] <= w_full ? '0 : w_cnt_ext[SLOT_OUT_W-1:0];
            r_hold_drop[r_sel] <= w_full;
        end
        if (w_load_out) begin
            r_out_a    <= w_pick_a_ext[VERT_OUT_W-1:0];
            r_out_b    <= w_pick_b_ext[VERT_OUT_W-1:0];
            r_out_slot <= r_hold_slot[w_pick];
            r_out_drop <= r_hold_drop[w_pick];
            r_out_last <= w_pick_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_slot, r_out_b, r_out_a};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_drop;

endmodule
